### rtl/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants of the page slot allocator
// Sizes of the count store and the page bitmap, request and status codes,
// and the control bundle between the top level and the bitmap unit.
// ----------------------------------------------------------------------------
package psa_pkg;

  // page space and count store
  localparam int MAX_PAGES          = 1024;
  localparam int PAGE_W             = $clog2(MAX_PAGES);
  localparam int MAX_SLOTS_PER_PAGE = 16;
  localparam int CNT_W              = 5;
  localparam int LIVE_W             = 11;
  localparam int SLOT_CAP           = 1024;
  localparam int SPP_W              = 5;
  localparam int PLIM_W             = 11;
  localparam int CAP_W              = PLIM_W + SPP_W;

  // page bitmap: words of BM_W bits, one bit per page, set while in use
  localparam int BM_W     = 32;
  localparam int BM_BW    = $clog2(BM_W);
  localparam int BM_WORDS = MAX_PAGES / BM_W;
  localparam int BM_AW    = $clog2(BM_WORDS);

  // config port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_SAME_PAGE  = 3'd0,
    ST_NEW_PAGE   = 3'd1,
    ST_FREED      = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_ALLOC_FAIL = 3'd4,
    ST_BAD_FREE   = 3'd5
  } status_e;

  typedef enum logic {
    REG_SLOTS_PER_PAGE = 1'b0,
    REG_PAGE_LIMIT     = 1'b1
  } reg_idx_e;

  // requests into the bitmap unit
  typedef struct packed {
    logic             rd_en;
    logic [BM_AW-1:0] rd_addr;
    logic             wr_en;
    logic [BM_AW-1:0] wr_addr;
    logic [BM_W-1:0]  wr_data;
  } bm_req_t;

  // answers from the bitmap unit
  typedef struct packed {
    logic [BM_W-1:0]  rd_data;    // word read last cycle, zero if never written
    logic [BM_AW-1:0] free_word;  // lowest word with a clear bit
    logic             free_any;   // some word has a clear bit
  } bm_rsp_t;

endpackage

### rtl/psa_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_bitmap: page occupancy bitmap
// One bit per page in a word memory, a per-word full flag for the
// lowest-free-word search, and per-word valid bits so reset needs no sweep.
// ----------------------------------------------------------------------------
module psa_bitmap
  import psa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bm_req_t req_i,
  output bm_rsp_t rsp_o
);

  logic [BM_W-1:0]     bm_mem [BM_WORDS];
  logic [BM_W-1:0]     rd_q;
  logic                rd_vld_q;
  logic [BM_WORDS-1:0] full_q;
  logic [BM_WORDS-1:0] vld_q;
  logic [BM_AW-1:0]    free_word;

  // word memory, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      bm_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= bm_mem[req_i.rd_addr];
    end
  end

  // full and valid flags per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        full_q[req_i.wr_addr] <= &req_i.wr_data;
        vld_q[req_i.wr_addr]  <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // lowest word that still has a free page
  always_comb begin
    free_word = '0;
    for (int i = BM_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        free_word = BM_AW'(i);
      end
    end
  end

  assign rsp_o.rd_data   = rd_vld_q ? rd_q : '0;
  assign rsp_o.free_word = free_word;
  assign rsp_o.free_any  = ~&full_q;

endmodule

### rtl/page_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_slot_allocator: slot allocator over fixed-size pages
// Bump allocation in the current page, lowest free page claimed when it is
// full, per-page free counting with release when all slots come back.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at the clock edge where start is high
//   and busy is low; opcode_i selects allocate or free, free_page_i names
//   the page for a free.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   page_index_o and live_slots_o; the receiver cannot stall it.
//   Config: APB-style port, slots_per_page at 0x0, page_limit at 0x4;
//   write only while no request is in flight. pready is tied high.
// Timing:
//   The accepting edge issues reads of the count memory and the bitmap
//   memory; the next cycle does the update and write-back and registers the
//   result, raising done_o with it.
//   busy is high in that execute state, so no new request is taken until
//   the read/modify/write of the count and bitmap memories is through.
// Reset:
//   Current page and live count read as zero right after reset; the
//   bitmap valid flags make the memories need no clearing pass.
// ----------------------------------------------------------------------------
module page_slot_allocator
  import psa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command
  input  logic                start,
  output logic                busy,
  input  logic                opcode_i,
  input  logic [PAGE_W-1:0]   free_page_i,
  // result
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [PAGE_W-1:0]   page_index_o,
  output logic [LIVE_W-1:0]   live_slots_o,
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e              state_q;
  logic                op_q;
  logic [PAGE_W-1:0]   page_q;
  logic [BM_AW-1:0]    fw_q;
  logic                fany_q;
  logic [PAGE_W-1:0]   cur_page_q, cur_page_d;
  logic                cur_valid_q, cur_valid_d;
  logic [LIVE_W-1:0]   live_q, live_d;
  logic                done_q;
  status_e             status_q;
  logic [PAGE_W-1:0]   pidx_q;
  logic [SPP_W-1:0]    spp_q;
  logic [PLIM_W-1:0]   plim_q;

  logic                accept;
  logic                cfg_we;

  // count memory: {alloc_count, free_count} per page
  logic [2*CNT_W-1:0]  cnt_mem [MAX_PAGES];
  logic [2*CNT_W-1:0]  cnt_rd_q;
  logic [PAGE_W-1:0]   cnt_raddr;
  logic                cnt_we;
  logic [PAGE_W-1:0]   cnt_waddr;
  logic [2*CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]    rd_alloc, rd_free, free_inc;

  bm_req_t             bm_req;
  bm_rsp_t             bm_rsp;

  logic [SPP_W-1:0]    size;
  logic [PLIM_W-1:0]   pages;
  logic [CAP_W-1:0]    cap_prod;
  logic [LIVE_W-1:0]   cap;
  logic                cap_fail, same_ok, claim_ok, page_used;
  logic [BM_BW-1:0]    claim_bit;
  logic [PAGE_W-1:0]   claim_page;
  logic [BM_W-1:0]     bm_word;
  status_e             res_status;
  logic [PAGE_W-1:0]   res_page;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cfg_we = psel && penable && pwrite && pready;

  // config readback
  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_SLOTS_PER_PAGE: prdata = APB_DW'(spp_q);
      REG_PAGE_LIMIT:     prdata = APB_DW'(plim_q);
      default:            prdata = '0;
    endcase
  end

  // effective config and slot capacity
  always_comb begin
    if (spp_q == '0) begin
      size = SPP_W'(1);
    end else if (spp_q > SPP_W'(MAX_SLOTS_PER_PAGE)) begin
      size = SPP_W'(MAX_SLOTS_PER_PAGE);
    end else begin
      size = spp_q;
    end
    if (plim_q == '0) begin
      pages = PLIM_W'(1);
    end else if (plim_q > PLIM_W'(MAX_PAGES)) begin
      pages = PLIM_W'(MAX_PAGES);
    end else begin
      pages = plim_q;
    end
    cap_prod = CAP_W'(pages) * CAP_W'(size);
    cap      = (cap_prod >= CAP_W'(SLOT_CAP)) ? LIVE_W'(SLOT_CAP) : cap_prod[LIVE_W-1:0];
  end

  // count memory
  assign cnt_raddr = (opcode_i == OP_FREE) ? free_page_i : cur_page_q;
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  assign rd_alloc = cnt_rd_q[2*CNT_W-1:CNT_W];
  assign rd_free  = cnt_rd_q[CNT_W-1:0];
  assign free_inc = rd_free + CNT_W'(1);
  assign bm_word  = bm_rsp.rd_data;

  // first clear bit of the word that holds the lowest free page
  always_comb begin
    claim_bit = '0;
    for (int i = BM_W - 1; i >= 0; i--) begin
      if (!bm_word[i]) begin
        claim_bit = BM_BW'(i);
      end
    end
  end

  assign claim_page = PAGE_W'({fw_q, claim_bit});
  assign cap_fail   = (live_q >= cap);
  assign same_ok    = cur_valid_q && (rd_alloc < size);
  assign claim_ok   = fany_q && (PLIM_W'(claim_page) < pages);
  assign page_used  = bm_word[page_q[BM_BW-1:0]];

  // execute: decide, modify and write back
  always_comb begin
    cnt_we         = 1'b0;
    cnt_waddr      = page_q;
    cnt_wdata      = '0;
    bm_req.rd_en   = accept;
    bm_req.rd_addr = (opcode_i == OP_FREE) ? free_page_i[PAGE_W-1:BM_BW] : bm_rsp.free_word;
    bm_req.wr_en   = 1'b0;
    bm_req.wr_addr = page_q[PAGE_W-1:BM_BW];
    bm_req.wr_data = bm_word;
    live_d         = live_q;
    cur_page_d     = cur_page_q;
    cur_valid_d    = cur_valid_q;
    res_status     = ST_ALLOC_FAIL;
    res_page       = '0;
    if (state_q == S_EXEC) begin
      if (op_q == OP_ALLOC) begin
        priority if (cap_fail) begin
          res_status = ST_ALLOC_FAIL;
        end else if (same_ok) begin
          cnt_we     = 1'b1;
          cnt_waddr  = cur_page_q;
          cnt_wdata  = {rd_alloc + CNT_W'(1), rd_free};
          live_d     = live_q + LIVE_W'(1);
          res_status = ST_SAME_PAGE;
          res_page   = cur_page_q;
        end else if (claim_ok) begin
          cnt_we         = 1'b1;
          cnt_waddr      = claim_page;
          cnt_wdata      = {CNT_W'(1), CNT_W'(0)};
          bm_req.wr_en   = 1'b1;
          bm_req.wr_addr = fw_q;
          bm_req.wr_data = bm_word | (BM_W'(1) << claim_bit);
          cur_page_d     = claim_page;
          cur_valid_d    = 1'b1;
          live_d         = live_q + LIVE_W'(1);
          res_status     = ST_NEW_PAGE;
          res_page       = claim_page;
        end else begin
          res_status = ST_ALLOC_FAIL;
        end
      end else begin
        res_page = page_q;
        if (!page_used) begin
          res_status = ST_BAD_FREE;
        end else begin
          live_d = (live_q != '0) ? live_q - LIVE_W'(1) : live_q;
          cnt_we = 1'b1;
          if (free_inc == rd_alloc) begin
            // last slot back: release the page
            cnt_wdata      = '0;
            bm_req.wr_en   = 1'b1;
            bm_req.wr_data = bm_word & ~(BM_W'(1) << page_q[BM_BW-1:0]);
            if (cur_valid_q && (cur_page_q == page_q)) begin
              cur_valid_d = 1'b0;
            end
            res_status = ST_RELEASED;
          end else begin
            cnt_wdata  = {rd_alloc, free_inc};
            res_status = ST_FREED;
          end
        end
      end
    end
  end

  psa_bitmap u_bitmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bm_req),
    .rsp_o  (bm_rsp)
  );

  // sequencer, allocator state, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ALLOC;
      page_q      <= '0;
      fw_q        <= '0;
      fany_q      <= 1'b0;
      cur_page_q  <= '0;
      cur_valid_q <= 1'b0;
      live_q      <= '0;
      done_q      <= 1'b0;
      status_q    <= ST_SAME_PAGE;
      pidx_q      <= '0;
      spp_q       <= SPP_W'(4);
      plim_q      <= PLIM_W'(256);
    end else begin
      done_q <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_e'(paddr[2]))
          REG_SLOTS_PER_PAGE: spp_q  <= pwdata[SPP_W-1:0];
          REG_PAGE_LIMIT:     plim_q <= pwdata[PLIM_W-1:0];
          default:            ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= opcode_i;
            page_q  <= free_page_i;
            fw_q    <= bm_rsp.free_word;
            fany_q  <= bm_rsp.free_any;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_page_q  <= cur_page_d;
          cur_valid_q <= cur_valid_d;
          live_q      <= live_d;
          status_q    <= res_status;
          pidx_q      <= res_page;
          done_q      <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign page_index_o = pidx_q;
  assign live_slots_o = live_q;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the page slot allocator
// Drives allocate and free commands against a cycle-free behavioral copy of
// the allocator, checks every result beat field by field in order, and moves
// slots_per_page and page_limit through several settings over the APB port.
// ----------------------------------------------------------------------------
module tb;
  import psa_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 175;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] page;
    logic [LIVE_W-1:0] live;
  } slot_result_t;

  // dut signals
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              opcode_i;
  logic [PAGE_W-1:0] free_page_i;
  logic              done_o;
  logic [2:0]        status_o;
  logic [PAGE_W-1:0] page_index_o;
  logic [LIVE_W-1:0] live_slots_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // allocator state as predicted
  logic [CNT_W-1:0]  page_alloc_cnt [MAX_PAGES];
  logic [CNT_W-1:0]  page_free_cnt  [MAX_PAGES];
  logic [PAGE_W-1:0] cur_page;
  bit                cur_valid;
  logic [LIVE_W-1:0] live_slots;
  logic [SPP_W-1:0]  cfg_slots;
  logic [PLIM_W-1:0] cfg_pages;

  slot_result_t expected_results[$];

  int  err_count;
  int  results_checked;
  int  n_alloc;
  int  n_free;
  int  n_cfg;
  int  status_hits [6];
  int  cycle_count;
  bit  no_idle;

  page_slot_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .free_page_i  (free_page_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .page_index_o (page_index_o),
    .live_slots_o (live_slots_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // allocator behavior: one request in, one result out, state updated
  function automatic slot_result_t predict_request(opcode_e op, logic [PAGE_W-1:0] pg);
    slot_result_t res;
    int unsigned  size;
    int unsigned  npages;
    int unsigned  cap;
    bit           found;
    size   = (cfg_slots == 0) ? 1 : cfg_slots;
    size   = (size > MAX_SLOTS_PER_PAGE) ? MAX_SLOTS_PER_PAGE : size;
    npages = (cfg_pages == 0) ? 1 : cfg_pages;
    npages = (npages > MAX_PAGES) ? MAX_PAGES : npages;
    cap    = npages * size;
    cap    = (cap > SLOT_CAP) ? SLOT_CAP : cap;
    found  = 1'b0;
    res.status = ST_ALLOC_FAIL;
    res.page   = '0;
    if (op == OP_ALLOC) begin
      if (live_slots < cap) begin
        if (cur_valid && page_alloc_cnt[cur_page] < size) begin
          page_alloc_cnt[cur_page] = page_alloc_cnt[cur_page] + 1'b1;
          live_slots = live_slots + 1'b1;
          res.status = ST_SAME_PAGE;
          res.page   = cur_page;
        end else begin
          // lowest page below the limit with nothing allocated
          for (int j = 0; j < npages; j++) begin
            if (!found && page_alloc_cnt[j] == 0) begin
              found             = 1'b1;
              page_alloc_cnt[j] = CNT_W'(1);
              page_free_cnt[j]  = '0;
              cur_page          = PAGE_W'(j);
              cur_valid         = 1'b1;
              live_slots        = live_slots + 1'b1;
              res.status        = ST_NEW_PAGE;
              res.page          = PAGE_W'(j);
            end
          end
        end
      end
    end else begin
      res.page = pg;
      if (page_alloc_cnt[pg] == 0) begin
        res.status = ST_BAD_FREE;
      end else begin
        page_free_cnt[pg] = page_free_cnt[pg] + 1'b1;
        if (live_slots != 0) live_slots = live_slots - 1'b1;
        if (page_free_cnt[pg] == page_alloc_cnt[pg]) begin
          page_alloc_cnt[pg] = '0;
          page_free_cnt[pg]  = '0;
          if (cur_valid && cur_page == pg) cur_valid = 1'b0;
          res.status = ST_RELEASED;
        end else begin
          res.status = ST_FREED;
        end
      end
    end
    res.live = live_slots;
    return res;
  endfunction

  // some page holding slots, searched from a random start; random if none
  function automatic logic [PAGE_W-1:0] pick_live_page();
    int unsigned       base;
    logic [PAGE_W-1:0] pg;
    bit                found;
    base  = $urandom_range(MAX_PAGES - 1);
    pg    = PAGE_W'(base);
    found = 1'b0;
    for (int n = 0; n < MAX_PAGES; n++) begin
      if (!found && page_alloc_cnt[PAGE_W'(base + n)] != 0) begin
        found = 1'b1;
        pg    = PAGE_W'(base + n);
      end
    end
    return pg;
  endfunction

  // result beats: compare with the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d page %0d live %0d",
               status_o, page_index_o, live_slots_o);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (page_index_o !== want.page) begin
          $error("page_index: expected %0d, got %0d", want.page, page_index_o);
          err_count++;
        end
        if (live_slots_o !== want.live) begin
          $error("live_slots: expected %0d, got %0d", want.live, live_slots_o);
          err_count++;
        end
      end
    end
  end

  // one command beat; returns right after the accepting edge
  task automatic send_request(input opcode_e op, input logic [PAGE_W-1:0] pg);
    start       <= 1'b1;
    opcode_i    <= op;
    free_page_i <= pg;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(predict_request(op, pg));
    if (op == OP_ALLOC) n_alloc++;
    else n_free++;
  endtask

  // random pause between beats
  task automatic idle_gap();
    if (!no_idle && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected result has come, then let the pipe settle
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready
  task automatic cfg_write(input reg_idx_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SLOTS_PER_PAGE) cfg_slots = SPP_W'(value);
    else cfg_pages = PLIM_W'(value);
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned spp, input int unsigned plim);
    drain_results();
    cfg_write(REG_SLOTS_PER_PAGE, spp);
    cfg_write(REG_PAGE_LIMIT, plim);
  endtask

  // reset geometry: bump within a page, claim, free, release, inactive frees
  task automatic test_basic_alloc_free();
    send_request(OP_FREE, 10'd5);
    send_request(OP_ALLOC, '0);
    repeat (3) send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    repeat (4) send_request(OP_FREE, 10'd0);
    send_request(OP_FREE, 10'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd1023);
    drain_results();
  endtask

  // capacity reached, then no free page below the limit
  task automatic test_capacity_and_no_page();
    set_geometry(2, 2);
    repeat (4) send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd0);
    repeat (2) send_request(OP_FREE, 10'd1);
    drain_results();
  endtask

  // limits lowered under a live current page, and out-of-range settings
  task automatic test_lowered_limits();
    set_geometry(MAX_SLOTS_PER_PAGE, MAX_PAGES);
    repeat (3) send_request(OP_ALLOC, '0);
    // current page now fuller than a page may be: a new page is claimed
    set_geometry(1, MAX_PAGES);
    send_request(OP_ALLOC, '0);
    // current page lies beyond the limit but still has room
    set_geometry(MAX_SLOTS_PER_PAGE, 1);
    send_request(OP_ALLOC, '0);
    // zero saturates up to one page of one slot
    set_geometry(0, 0);
    send_request(OP_ALLOC, '0);
    // oversize values saturate down to the maximum
    set_geometry(31, 2047);
    send_request(OP_ALLOC, '0);
    drain_results();
  endtask

  // phases of mixed traffic, each under its own geometry and alloc/free mix
  task automatic test_random_traffic();
    int unsigned spp;
    int unsigned plim;
    int unsigned alloc_pct;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        spp  = MAX_SLOTS_PER_PAGE;
        plim = MAX_PAGES;
      end else if (phase == 1) begin
        spp  = 1;
        plim = 1;
      end else begin
        case ($urandom_range(7))
          0: begin
            spp  = $urandom_range(1) ? 0 : $urandom_range(17, 31);
            plim = $urandom_range(1) ? 0 : $urandom_range(1025, 2047);
          end
          1: begin
            spp  = $urandom_range(1, 16);
            plim = $urandom_range(1, 1024);
          end
          default: begin
            spp  = $urandom_range(1, 16);
            plim = $urandom_range(1, 8);
          end
        endcase
      end
      set_geometry(spp, plim);
      alloc_pct = $urandom_range(30, 75);
      no_idle   = (phase == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < alloc_pct) begin
          send_request(OP_ALLOC, PAGE_W'($urandom));
        end else if ($urandom_range(99) < 85) begin
          send_request(OP_FREE, pick_live_page());
        end else begin
          send_request(OP_FREE, PAGE_W'($urandom));
        end
        if ((phase == 2 && k == 80) || $urandom_range(199) == 0) drain_results();
        else idle_gap();
      end
      no_idle = 1'b0;
    end
    drain_results();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    opcode_i    <= OP_ALLOC;
    free_page_i <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    for (int p = 0; p < MAX_PAGES; p++) begin
      page_alloc_cnt[p] = '0;
      page_free_cnt[p]  = '0;
    end
    cur_page   = '0;
    cur_valid  = 1'b0;
    live_slots = '0;
    cfg_slots  = SPP_W'(4);
    cfg_pages  = PLIM_W'(256);
    no_idle    = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_alloc_free();
    test_capacity_and_no_page();
    test_lowered_limits();
    test_random_traffic();

    $display("covered %0d requests (%0d alloc, %0d free), %0d register writes, %0d results",
             n_alloc + n_free, n_alloc, n_free, n_cfg, results_checked);
    $display("status mix: same %0d, new %0d, freed %0d, released %0d, fail %0d, bad free %0d",
             status_hits[ST_SAME_PAGE], status_hits[ST_NEW_PAGE], status_hits[ST_FREED],
             status_hits[ST_RELEASED], status_hits[ST_ALLOC_FAIL], status_hits[ST_BAD_FREE]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/psa_pkg.sv
rtl/psa_bitmap.sv
rtl/page_slot_allocator.sv
sim/tb.sv
